FILE: src/hsr_pkg.sv
`default_nettype none
package hsr_pkg;

    localparam int unsigned KeyW   = 64;
    localparam int unsigned CountW = 32;
    localparam int unsigned AddrW  = 3;

    localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;
    localparam int unsigned MixShA  = 30;
    localparam int unsigned MixShB  = 27;
    localparam int unsigned MixShC  = 31;

    localparam logic CmdRoute = 1'b0;
    localparam logic CmdRange = 1'b1;

    localparam logic [AddrW-1:0] RegCount = 3'd0;
    localparam logic [AddrW-1:0] RegOwn   = 3'd4;

    localparam logic [31:0] CountReset = 32'd1;
    localparam logic [31:0] OwnReset   = 32'd0;

    // Item context carried beside the data through every stage
    typedef struct packed {
        logic        cmd;
        logic        ok;
        logic        zero_cnt;
        logic [31:0] cnt;
        logic [31:0] own;
    } t_ctx;

endpackage
`default_nettype wire

FILE: src/hsr_mul64.sv
`default_nettype none
// 64x64 low-half product, cut into 32-bit partial products over two stages.
// Stage 1 registers the three partial products, stage 2 sums them.
module hsr_mul64 #(
    parameter int unsigned SideW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [63:0]      i_a,
    input  wire logic [63:0]      i_b,
    input  wire logic [SideW-1:0] i_side,
    output logic      [63:0]      o_p,
    output logic      [SideW-1:0] o_side
);
    logic [63:0]      r_ll;
    logic [31:0]      r_lh;
    logic [31:0]      r_hl;
    logic [SideW-1:0] r_side1;
    logic [63:0]      r_p;
    logic [SideW-1:0] r_side2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= i_a[31:0] * i_b[31:0];
            r_lh    <= 32'(i_a[31:0] * i_b[63:32]);
            r_hl    <= 32'(i_a[63:32] * i_b[31:0]);
            r_side1 <= i_side;
            r_p     <= r_ll + {r_lh + r_hl, 32'd0};
            r_side2 <= r_side1;
        end
    end

    assign o_p    = r_p;
    assign o_side = r_side2;
endmodule
`default_nettype wire

FILE: src/hsr_div64.sv
`default_nettype none
// Pipelined restoring divider: 64-bit dividend by 32-bit divisor,
// one quotient bit per stage, 64 stages. Remainder stays below a nonzero divisor.
module hsr_div64 #(
    parameter int unsigned SideW = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [63:0]      i_num,
    input  wire logic [31:0]      i_den,
    input  wire logic [SideW-1:0] i_side,
    output logic      [63:0]      o_quo,
    output logic      [31:0]      o_rem,
    output logic      [SideW-1:0] o_side
);
    localparam int unsigned Steps = 64;

    logic [63:0]      r_num  [Steps];
    logic [31:0]      r_rem  [Steps];
    logic [31:0]      r_den  [Steps];
    logic [SideW-1:0] r_side [Steps];

    for (genvar s = 0; s < Steps; s++) begin : g_step
        logic [63:0]      num_in;
        logic [31:0]      rem_in;
        logic [31:0]      den_in;
        logic [SideW-1:0] side_in;
        logic [32:0]      trial;
        logic             fits;

        if (s == 0) begin : g_first
            assign num_in  = i_num;
            assign rem_in  = 32'd0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign num_in  = r_num[s-1];
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign trial = {rem_in, num_in[63]};
        assign fits  = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= fits ? 32'(trial - {1'b0, den_in}) : trial[31:0];
                r_num[s]  <= {num_in[62:0], fits};
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_quo  = r_num[Steps-1];
    assign o_rem  = r_rem[Steps-1];
    assign o_side = r_side[Steps-1];
endmodule
`default_nettype wire

FILE: src/hash_shard_router.sv
`default_nettype none
// Key-to-shard router and balanced range slicer.
// Input stream (s_axis): tuser = cmd (0 route, 1 range); tdata = route_key in
// [63:0], range_total in [127:64]. Output stream (m_axis): tuser = status;
// tdata = target_shard [31:0], owned_here [32], slice_begin [96:33],
// slice_end [160:97], zero filled to 168 bits.
// Route mixes the key (xor-shift, two 64-bit multiplies) and reduces it
// modulo shard_total_count; range divides range_total by the count and
// places this shard's slice. Registers over APB: shard_total_count at 0x0,
// own_shard_index at 0x4; write them only while the block is idle.
// Throughput: one item per cycle while the output is not stalled. Between
// acceptance and the result register lie 5 mixing stages, 64 divider stages
// and 4 slicing/output stages, most of them in the bit-per-stage divider.
// The whole pipeline advances only when its output register is free or being
// taken, so a receiver stall freezes every stage and nothing is lost.
// Reset clears valid bits and sets count to CountInit (1 by default), own index to OwnInit (0 by default).
module hash_shard_router #(
    parameter logic [31:0] CountInit = hsr_pkg::CountReset,
    parameter logic [31:0] OwnInit   = hsr_pkg::OwnReset
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire logic [127:0]               s_axis_tdata,  // route_key, range_total
    input  wire logic                       s_axis_tuser,  // cmd
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic      [167:0]               m_axis_tdata,  // target, owned, begin, end
    output logic                            m_axis_tuser,  // status
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hsr_pkg::AddrW-1:0]  paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    localparam int unsigned CtxW = $bits(hsr_pkg::t_ctx);
    localparam int unsigned Lat  = 73;

    logic [31:0] r_cnt;
    logic [31:0] r_own;

    // configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CountInit;
            r_own <= OwnInit;
        end else if (psel && penable && pwrite) begin
            case (paddr)
                hsr_pkg::RegCount: r_cnt <= pwdata;
                hsr_pkg::RegOwn:   r_own <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            hsr_pkg::RegCount: prdata = r_cnt;
            hsr_pkg::RegOwn:   prdata = r_own;
            default:           prdata = 32'd0;
        endcase
    end

    // global advance: output register empty or being drained
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [Lat-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[Lat-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = r_vld[Lat-1];

    // stage 0: first xor-shift, context capture
    hsr_pkg::t_ctx ctx_in;
    assign ctx_in.cmd      = s_axis_tuser;
    assign ctx_in.ok       = (r_cnt != 32'd0) && (r_own < r_cnt);
    assign ctx_in.zero_cnt = (r_cnt == 32'd0);
    assign ctx_in.cnt      = r_cnt;
    assign ctx_in.own      = r_own;

    logic [63:0]   r_x0;
    logic [63:0]   r_tot0;
    hsr_pkg::t_ctx r_ctx0;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0   <= s_axis_tdata[63:0] ^ (s_axis_tdata[63:0] >> hsr_pkg::MixShA);
            r_tot0 <= s_axis_tdata[127:64];
            r_ctx0 <= ctx_in;
        end
    end

    // first multiply (2 stages)
    logic [63:0]          m1;
    logic [64+CtxW-1:0]   m1_side;
    hsr_mul64 #(.SideW(64 + CtxW)) u_mul_a (
        .i_clk (i_clk), .i_en (en), .i_a (r_x0), .i_b (hsr_pkg::MixMulA),
        .i_side ({r_tot0, r_ctx0}), .o_p (m1), .o_side (m1_side)
    );

    logic [63:0] x1;
    assign x1 = m1 ^ (m1 >> hsr_pkg::MixShB);

    // second multiply (2 stages) with xor-shift before it
    logic [63:0]        m2;
    logic [64+CtxW-1:0] m2_side;
    hsr_mul64 #(.SideW(64 + CtxW)) u_mul_b (
        .i_clk (i_clk), .i_en (en), .i_a (x1), .i_b (hsr_pkg::MixMulB),
        .i_side (m1_side), .o_p (m2), .o_side (m2_side)
    );

    // shared divider input: mixed key for route, total for range
    hsr_pkg::t_ctx ctx2;
    logic [63:0]   tot2;
    logic [63:0]   mixed;
    assign {tot2, ctx2} = m2_side;
    assign mixed        = m2 ^ (m2 >> hsr_pkg::MixShC);

    logic [63:0]   quo;
    logic [31:0]   rem;
    hsr_pkg::t_ctx ctx3;
    hsr_div64 #(.SideW(CtxW)) u_div (
        .i_clk (i_clk), .i_en (en),
        .i_num ((ctx2.cmd == hsr_pkg::CmdRange) ? tot2 : mixed),
        .i_den (ctx2.cnt), .i_side (ctx2),
        .o_quo (quo), .o_rem (rem), .o_side (ctx3)
    );

    // slice stage A: id*base partial products, id<rem compare
    logic [63:0]   r_pl;
    logic [31:0]   r_ph;
    logic          r_lt;
    logic [31:0]   r_rem4;
    logic [63:0]   r_quo4;
    hsr_pkg::t_ctx r_ctx4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pl   <= ctx3.own * quo[31:0];
            r_ph   <= 32'(ctx3.own * quo[63:32]);
            r_lt   <= ctx3.own < rem;
            r_rem4 <= rem;
            r_quo4 <= quo;
            r_ctx4 <= ctx3;
        end
    end

    // slice stage B: begin
    logic [63:0]   r_beg5;
    logic          r_lt5;
    logic [31:0]   r_rem5;
    logic [63:0]   r_quo5;
    hsr_pkg::t_ctx r_ctx5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_beg5 <= r_pl + {r_ph, 32'd0}
                    + {32'd0, (r_lt ? r_ctx4.own : r_rem4)};
            r_lt5  <= r_lt;
            r_rem5 <= r_rem4;
            r_quo5 <= r_quo4;
            r_ctx5 <= r_ctx4;
        end
    end

    // slice stage C: end
    logic [63:0]   r_beg6;
    logic [63:0]   r_end6;
    logic [31:0]   r_rem6;
    hsr_pkg::t_ctx r_ctx6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_beg6 <= r_beg5;
            r_end6 <= r_beg5 + r_quo5 + {63'd0, r_lt5};
            r_rem6 <= r_rem5;
            r_ctx6 <= r_ctx5;
        end
    end

    // output register
    logic        r_status;
    logic [31:0] r_tgt;
    logic        r_owned;
    logic [63:0] r_beg;
    logic [63:0] r_end;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_status <= !r_ctx6.ok;
            if (r_ctx6.cmd == hsr_pkg::CmdRoute) begin
                r_tgt   <= r_ctx6.zero_cnt ? 32'hffffffff : r_rem6;
                r_owned <= r_ctx6.ok && (r_rem6 == r_ctx6.own);
                r_beg   <= 64'd0;
                r_end   <= 64'd0;
            end else begin
                r_tgt   <= 32'd0;
                r_owned <= 1'b0;
                r_beg   <= r_ctx6.ok ? r_beg6 : 64'd0;
                r_end   <= r_ctx6.ok ? r_end6 : 64'd0;
            end
        end
    end

    assign m_axis_tdata = {7'd0, r_end, r_beg, r_owned, r_tgt};
    assign m_axis_tuser = r_status;
endmodule
`default_nettype wire
